>>> rtl/core/rtp_header_parser_unit_defines.svh
`ifndef RTP_HEADER_PARSER_UNIT_DEFINES_SVH
`define RTP_HEADER_PARSER_UNIT_DEFINES_SVH

// Concurrent checks that hold in the cycle of the antecedent.
`define RTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtp header parser check failed");

// Concurrent checks that hold in the cycle after the antecedent.
`define RTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtp header parser check failed");

`endif

>>> rtl/core/rtp_hdr_pkg.sv
package rtp_hdr_pkg;

	localparam int unsigned MAX_PACKET_BYTES_DEF = 49152;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned SKIP_W = 19;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_TDATA_W = 152;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT       = 3'd1,
		ST_OVERSIZE    = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_BAD_PADDING = 3'd4
	} status_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [31:0]        first_word;
		logic [31:0]        time_word;
		logic [31:0]        source_word;
		logic [15:0]        ext_words;
		logic               ext_seen;
		logic               too_long;
	} pkt_state_t;

	// The first field sits in the lowest bits, so it is the last member here.
	typedef struct packed {
		logic [15:0]        payload_length;
		logic [15:0]        payload_offset;
		logic [SKIP_W-1:0]  header_skip;
		logic               has_extension;
		logic [3:0]         csrc_count;
		logic [31:0]        ssrc;
		logic [31:0]        timestamp;
		logic [15:0]        seq_num;
		logic [6:0]         payload_type;
		logic               marker;
		status_t            status;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

endpackage

>>> rtl/core/rtp_hdr_accum.sv
module rtp_hdr_accum import rtp_hdr_pkg::*; #(
	parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       last,
	output pkt_state_t nxt
);

	localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_PACKET_BYTES);

	pkt_state_t       state_q;
	logic [6:0]       ext_at;
	logic [COUNT_W-1:0] p;

	assign p = state_q.count;

	always_comb begin
		nxt = state_q;
		ext_at = '0;
		if (p >= MaxCount) begin
			nxt.too_long = 1'b1;
		end else begin
			if (p < COUNT_W'(4)) begin
				nxt.first_word = {state_q.first_word[23:0], data_byte};
			end else if (p < COUNT_W'(8)) begin
				nxt.time_word = {state_q.time_word[23:0], data_byte};
			end else if (p < COUNT_W'(12)) begin
				nxt.source_word = {state_q.source_word[23:0], data_byte};
			end
			ext_at = 7'd12 + {1'b0, nxt.first_word[27:24], 2'b00};
			if (p == COUNT_W'(ext_at) + COUNT_W'(2)) begin
				nxt.ext_words = {data_byte, 8'h00};
			end else if (p == COUNT_W'(ext_at) + COUNT_W'(3)) begin
				nxt.ext_words = {state_q.ext_words[15:8], data_byte};
				nxt.ext_seen = 1'b1;
			end
			nxt.count = p + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			state_q <= last ? '0 : nxt;
		end
	end

endmodule

>>> rtl/core/rtp_hdr_result.sv
module rtp_hdr_result import rtp_hdr_pkg::*; (
	input  pkt_state_t st,
	input  logic [7:0] final_byte,
	output result_t    res
);

	logic [7:0]         pad;
	logic [COUNT_W:0]   len_full;
	logic [COUNT_W-1:0] len;
	logic [SKIP_W-1:0]  skip;
	logic [6:0]         ext_end;
	logic [SKIP_W-1:0]  ext_bytes;

	always_comb begin
		res = '0;
		pad = st.first_word[29] ? final_byte : 8'h00;
		len_full = {1'b0, st.count} - {{(COUNT_W-7){1'b0}}, pad};
		len = len_full[COUNT_W-1:0];
		ext_end = 7'd16 + {1'b0, st.first_word[27:24], 2'b00};
		ext_bytes = {1'b0, st.ext_words, 2'b00};
		skip = SKIP_W'(12) + SKIP_W'({st.first_word[27:24], 2'b00});
		if (st.first_word[28]) begin
			skip = skip + SKIP_W'(4);
			if (st.ext_seen && (COUNT_W'(ext_end) <= len)) begin
				skip = skip + ext_bytes;
			end
		end

		if (!st.too_long && st.count < COUNT_W'(12)) begin
			res.status = ST_SHORT;
		end else if (st.too_long) begin
			res.status = ST_OVERSIZE;
		end else if (st.first_word[31:30] != 2'b10) begin
			res.status = ST_BAD_VERSION;
		end else begin
			res.marker = st.first_word[23];
			res.payload_type = st.first_word[22:16];
			res.seq_num = st.first_word[15:0];
			if (len_full[COUNT_W]) begin
				res.status = ST_BAD_PADDING;
			end else begin
				res.status = ST_OK;
				res.timestamp = st.time_word;
				res.ssrc = st.source_word;
				res.csrc_count = st.first_word[27:24];
				res.has_extension = st.first_word[28];
				res.header_skip = skip;
				res.payload_offset = (skip < SKIP_W'(len)) ? skip[COUNT_W-1:0] : len;
				res.payload_length = len;
			end
		end
	end

endmodule

>>> rtl/core/rtp_header_parser_unit.sv
// RTP fixed-header parser. Packet bytes enter on the slave stream one per transfer,
// with tlast on the final byte, and one result transfer leaves on the master stream
// per packet. A byte can be taken on every clock cycle; the result appears in the cycle
// after the final byte is taken. The input only stalls when a finished result is still
// waiting on the master side and the next final byte needs the result register.
// Bytes beyond MAX_PACKET_BYTES are dropped and flag the packet as oversize.
module rtp_header_parser_unit import rtp_hdr_pkg::*; #(
	parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // data_byte
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status, marker, payload_type, seq_num, timestamp, ssrc, csrc_count,
	// has_extension, header_skip, payload_offset, payload_length, zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_free;
	logic       take;
	pkt_state_t nxt;
	result_t    res;
	result_t    res_q;
	logic       m_tvalid_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign take = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	rtp_hdr_accum #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.data_byte(byte_s1),
		.last(last_s1),
		.nxt(nxt)
	);

	rtp_hdr_result u_result (
		.st(nxt),
		.final_byte(byte_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(OUT_TDATA_W-RESULT_W){1'b0}}, res_q};

endmodule

>>> rtl/core/rtp_hdr_checker.sv
`include "rtp_header_parser_unit_defines.svh"

module rtp_hdr_checker import rtp_hdr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	result_t res;

	assign res = result_t'(m_tdata[RESULT_W-1:0]);

	`RTP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))
	`RTP_ASSERT_NOW(a_status_known, clk, arst_n, m_tvalid,
		res.status == ST_OK || res.status == ST_SHORT || res.status == ST_OVERSIZE ||
		res.status == ST_BAD_VERSION || res.status == ST_BAD_PADDING)
	`RTP_ASSERT_NOW(a_error_zero, clk, arst_n, m_tvalid && res.status != ST_OK,
		res.timestamp == '0 && res.ssrc == '0 && res.header_skip == '0 &&
		res.payload_offset == '0 && res.payload_length == '0)
	`RTP_ASSERT_NOW(a_offset_clamp, clk, arst_n, m_tvalid && res.status == ST_OK,
		res.payload_offset <= res.payload_length &&
		SKIP_W'(res.payload_offset) <= res.header_skip)

endmodule

bind rtp_header_parser_unit rtp_hdr_checker u_rtp_hdr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
